// ----- sv/qdra_pkg.sv -----
// ----------------------------------------------------------------------------
// qdra_pkg
// Shared types and constants for the queue-driven rate adjuster: event and
// action codes, register map, configuration reset values and divider request.
// ----------------------------------------------------------------------------
package qdra_pkg;

  // Event codes carried in func.
  localparam logic [1:0] FuncEnq  = 2'd0;
  localparam logic [1:0] FuncSrv  = 2'd1;
  localparam logic [1:0] FuncSlot = 2'd2;
  localparam logic [1:0] FuncStop = 2'd3;

  // Rate action codes.
  localparam logic [1:0] ActNone  = 2'd0;
  localparam logic [1:0] ActApply = 2'd1;
  localparam logic [1:0] ActMin   = 2'd2;

  // Register indexes (byte address is four times the index).
  localparam logic [1:0] RegMtu    = 2'd0;
  localparam logic [1:0] RegTarget = 2'd1;
  localparam logic [1:0] RegMax    = 2'd2;

  // Configuration reset values.
  localparam logic [15:0] MtuReset    = 16'd1500;
  localparam logic [7:0]  TargetReset = 8'd5;
  localparam logic [7:0]  MaxReset    = 8'd10;

  // Divider geometry: 56-bit dividend, 24-bit divisor, 34 quotient bits.
  localparam int DivSteps = 34;
  localparam int DivCntW  = $clog2(DivSteps + 1);

  typedef struct packed {
    logic [15:0] mtu_bytes;
    logic [7:0]  target_packets;
    logic [7:0]  max_packets;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [55:0] dividend;
    logic [23:0] divisor;
  } div_req_t;

endpackage

// ----- sv/qdra_cfg.sv -----
// ----------------------------------------------------------------------------
// qdra_cfg
// APB-style register file holding the MTU, target and maximum packet counts.
// ----------------------------------------------------------------------------
module qdra_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output qdra_pkg::cfg_t cfg_o
);
  import qdra_pkg::*;

  logic [15:0] mtu_q;
  logic [7:0]  target_q;
  logic [7:0]  max_q;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Register writes on the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mtu_q    <= MtuReset;
      target_q <= TargetReset;
      max_q    <= MaxReset;
    end else if (wr_en) begin
      case (reg_idx)
        RegMtu:    mtu_q    <= pwdata[15:0];
        RegTarget: target_q <= pwdata[7:0];
        RegMax:    max_q    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    case (reg_idx)
      RegMtu:    prdata = {16'd0, mtu_q};
      RegTarget: prdata = {24'd0, target_q};
      RegMax:    prdata = {24'd0, max_q};
      default:   prdata = 32'd0;
    endcase
  end

  assign cfg_o = '{mtu_bytes: mtu_q, target_packets: target_q, max_packets: max_q};

endmodule

// ----- sv/qdra_div.sv -----
// ----------------------------------------------------------------------------
// qdra_div
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in DivSteps bits and that the divisor is not zero.
// ----------------------------------------------------------------------------
module qdra_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qdra_pkg::div_req_t req_i,
  output logic               done_o,
  output logic [33:0]        quot_o
);
  import qdra_pkg::*;

  logic               busy_q;
  logic               done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [23:0]        rem_q;
  logic [33:0]        dq_q;
  logic [23:0]        divisor_q;
  logic [24:0]        trial;
  logic               ge;

  // One trial subtraction per cycle.
  assign trial = {rem_q, dq_q[33]};
  assign ge    = trial >= {1'b0, divisor_q};

  // Control: count the steps and flag the last one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= DivCntW'(DivSteps);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= (cnt_q != DivCntW'(1));
      done_q <= (cnt_q == DivCntW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  // Datapath: partial remainder and the dividend/quotient shift register.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q     <= {2'b00, req_i.dividend[55:34]};
      dq_q      <= req_i.dividend[33:0];
      divisor_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? 24'(trial - {1'b0, divisor_q}) : trial[23:0];
      dq_q  <= {dq_q[32:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule

// ----- sv/queue_driven_rate_adjuster.sv -----
// ----------------------------------------------------------------------------
// queue_driven_rate_adjuster
// Tracks queue occupancy in bytes and proposes a new sending rate per event.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid_i/in_ready_o) carries one event word: func_i,
// packet_len_i and current_rate_i. Every accepted word yields exactly one
// result word on the output channel (out_valid_o/out_ready_i).
// The block works on one word at a time; in_ready_o is high only while the
// sequencer is idle. A slot tick can divide twice (rate, then occupancy
// report). A division runs 34 quotient steps in the shared bit-serial
// divider; the sequencer then collects the quotient. The next word can be
// accepted in the same cycle that out_valid_o rises.
// A finished result sits in the output register; a new word is accepted while
// it waits, and the sequencer holds its next result until the register frees.
// Reset clears occupancy, marks the block not started but running, and loads
// the default MTU (1500), target (5) and maximum (10) packet counts.
// Configuration is to be written through the APB port only while the block is
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module queue_driven_rate_adjuster (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Event channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [15:0] packet_len_i,
  input  logic [31:0] current_rate_i,
  // Result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  rate_action_o,
  output logic [31:0] new_rate_o,
  output logic        trace_valid_o,
  output logic [25:0] queue_packets_o
);
  import qdra_pkg::*;

  // Sequencer states.
  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StAdd  = 4'd1;
  localparam logic [3:0] StSrv  = 4'd2;
  localparam logic [3:0] StChk  = 4'd3;
  localparam logic [3:0] StAdj  = 4'd4;
  localparam logic [3:0] StDivA = 4'd5;
  localparam logic [3:0] StRep  = 4'd6;
  localparam logic [3:0] StDivR = 4'd7;
  localparam logic [3:0] StOut  = 4'd8;

  cfg_t       cfg;
  div_req_t   div_req;
  logic       div_done;
  logic [33:0] div_quot;

  logic [3:0]  state_q, state_d;
  logic [1:0]  func_q, func_d;
  logic [15:0] len_q, len_d;
  logic [31:0] rate_q, rate_d;
  logic [23:0] tgt_q, tgt_d;
  logic [23:0] mx_q, mx_d;
  logic [31:0] occ_q, occ_d;
  logic        started_q, started_d;
  logic        running_q, running_d;
  logic [1:0]  res_act_q, res_act_d;
  logic [31:0] res_rate_q, res_rate_d;
  logic        res_tv_q, res_tv_d;
  logic [25:0] res_qp_q, res_qp_d;
  logic        out_valid_q, out_valid_d;
  logic [1:0]  out_act_q, out_act_d;
  logic [31:0] out_rate_q, out_rate_d;
  logic        out_tv_q, out_tv_d;
  logic [25:0] out_qp_q, out_qp_d;

  logic [32:0] occ_sum;
  logic [32:0] rate_inc9;
  logic [32:0] rate_inc5;
  logic [34:0] occ_x5;
  logic [34:0] tgt_x4;
  logic        out_free;

  qdra_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  qdra_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // Arithmetic shared by the sequencer states.
  assign occ_sum   = {1'b0, occ_q} + {17'd0, len_q};
  assign rate_inc9 = {1'b0, rate_q} + {4'd0, rate_q[31:3]};
  assign rate_inc5 = {1'b0, rate_q} + {3'd0, rate_q[31:2]};
  assign occ_x5    = {1'b0, occ_q, 2'b00} + {3'd0, occ_q};
  assign tgt_x4    = {9'd0, tgt_q, 2'b00};
  assign out_free  = !out_valid_q || out_ready_i;

  // Event sequencer.
  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    len_d       = len_q;
    rate_d      = rate_q;
    tgt_d       = tgt_q;
    mx_d        = mx_q;
    occ_d       = occ_q;
    started_d   = started_q;
    running_d   = running_q;
    res_act_d   = res_act_q;
    res_rate_d  = res_rate_q;
    res_tv_d    = res_tv_q;
    res_qp_d    = res_qp_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_act_d   = out_act_q;
    out_rate_d  = out_rate_q;
    out_tv_d    = out_tv_q;
    out_qp_d    = out_qp_q;
    div_req     = '0;

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          func_d     = func_i;
          len_d      = packet_len_i;
          rate_d     = current_rate_i;
          tgt_d      = 24'(cfg.target_packets) * 24'(cfg.mtu_bytes);
          mx_d       = 24'(cfg.max_packets) * 24'(cfg.mtu_bytes);
          res_act_d  = ActNone;
          res_rate_d = '0;
          res_tv_d   = 1'b0;
          res_qp_d   = '0;
          if (!running_q) begin
            state_d = StOut;
          end else begin
            case (func_i)
              FuncEnq:  state_d = StAdd;
              FuncSrv:  state_d = started_q ? StSrv : StOut;
              FuncSlot: state_d = started_q ? StAdj : StOut;
              default: begin
                running_d = 1'b0;
                state_d   = StOut;
              end
            endcase
          end
        end
      end
      StAdd: begin
        // Saturating add of the packet length.
        occ_d = occ_sum[32] ? '1 : occ_sum[31:0];
        if (!started_q) begin
          started_d = 1'b1;
          state_d   = StSrv;
        end else begin
          state_d = StOut;
        end
      end
      StSrv: begin
        // Remove one MTU when at least that much is queued.
        if (occ_q >= {16'd0, cfg.mtu_bytes}) begin
          occ_d = occ_q - {16'd0, cfg.mtu_bytes};
        end
        state_d = StChk;
      end
      StChk: begin
        state_d = (occ_q > {8'd0, tgt_q}) ? StAdj : StOut;
      end
      StAdj: begin
        // Pick the adjustment; the ratio case starts the divider.
        if (occ_q == '0) begin
          res_act_d  = ActApply;
          res_rate_d = rate_inc9[32] ? '1 : rate_inc9[31:0];
          state_d    = (func_q == FuncSlot) ? StRep : StOut;
        end else if (occ_q < {8'd0, mx_q}) begin
          res_act_d = ActApply;
          if (tgt_x4 > occ_x5) begin
            res_rate_d = rate_inc5[32] ? '1 : rate_inc5[31:0];
            state_d    = (func_q == FuncSlot) ? StRep : StOut;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = 56'(rate_q) * 56'(tgt_q);
            div_req.divisor  = occ_q[23:0];
            state_d          = StDivA;
          end
        end else begin
          res_act_d = ActMin;
          state_d   = (func_q == FuncSlot) ? StRep : StOut;
        end
      end
      StDivA: begin
        if (div_done) begin
          res_rate_d = (|div_quot[33:32]) ? '1 : div_quot[31:0];
          state_d    = (func_q == FuncSlot) ? StRep : StOut;
        end
      end
      StRep: begin
        // Occupancy report in packets.
        res_tv_d = 1'b1;
        if (cfg.mtu_bytes == '0) begin
          res_qp_d = '1;
          state_d  = StOut;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = {24'd0, occ_q};
          div_req.divisor  = {8'd0, cfg.mtu_bytes};
          state_d          = StDivR;
        end
      end
      StDivR: begin
        if (div_done) begin
          res_qp_d = (|div_quot[33:26]) ? '1 : div_quot[25:0];
          state_d  = StOut;
        end
      end
      StOut: begin
        // Hand the result to the output register once it is free.
        if (out_free) begin
          out_valid_d = 1'b1;
          out_act_d   = res_act_q;
          out_rate_d  = res_rate_q;
          out_tv_d    = res_tv_q;
          out_qp_d    = res_qp_q;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      occ_q       <= '0;
      started_q   <= 1'b0;
      running_q   <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      started_q   <= started_d;
      running_q   <= running_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    len_q      <= len_d;
    rate_q     <= rate_d;
    tgt_q      <= tgt_d;
    mx_q       <= mx_d;
    res_act_q  <= res_act_d;
    res_rate_q <= res_rate_d;
    res_tv_q   <= res_tv_d;
    res_qp_q   <= res_qp_d;
    out_act_q  <= out_act_d;
    out_rate_q <= out_rate_d;
    out_tv_q   <= out_tv_d;
    out_qp_q   <= out_qp_d;
  end

  assign in_ready_o      = (state_q == StIdle);
  assign out_valid_o     = out_valid_q;
  assign rate_action_o   = out_act_q;
  assign new_rate_o      = out_rate_q;
  assign trace_valid_o   = out_tv_q;
  assign queue_packets_o = out_qp_q;

endmodule

// ----- sv/qdra_checker.sv -----
// ----------------------------------------------------------------------------
// qdra_checker
// Port-level checks of the rate adjuster, attached to the top level by bind.
// ----------------------------------------------------------------------------
module qdra_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pready,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic [1:0]  rate_action_o,
  input logic [31:0] new_rate_o,
  input logic        trace_valid_o,
  input logic [25:0] queue_packets_o
);
  import qdra_pkg::*;

  // The configuration port never inserts wait states.
  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready dropped");

  // A word keeps the block busy for at least the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted back to back");

  // Only the defined action codes appear.
  a_action_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (rate_action_o == ActNone || rate_action_o == ActApply ||
                     rate_action_o == ActMin))
    else $error("undefined rate action");

  // A proposed rate is shown only with the apply action.
  a_rate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && rate_action_o != ActApply) |-> (new_rate_o == '0))
    else $error("new rate without apply action");

  // The occupancy report is zero outside slot ticks.
  a_report_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !trace_valid_o) |-> (queue_packets_o == '0))
    else $error("queue report without trace");

endmodule

bind queue_driven_rate_adjuster qdra_checker u_qdra_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .pready          (pready),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .rate_action_o   (rate_action_o),
  .new_rate_o      (new_rate_o),
  .trace_valid_o   (trace_valid_o),
  .queue_packets_o (queue_packets_o)
);
